### rtl/core/assert_macros.svh
// Assertion helpers used by the histogram unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// The consequent holds at the same edge as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds at the edge after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/phhel_pkg.sv
package phhel_pkg;

    localparam int BIN_COUNT = 64;
    localparam int LOG_DEPTH = 256;

    localparam int BIN_AW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam int LOG_AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

    localparam int ACTION_W = 2;
    localparam int RAW_W = 16;
    localparam int STAMP_W = 16;
    localparam int INDEX_W = 8;
    localparam int OUTCOME_W = 2;
    localparam int COUNT_W = 16;
    localparam int LEVEL_W = 14;
    localparam int THRESH_W = 7;
    localparam int LEVEL_SHIFT = 2;

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(64);
    localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_SAMPLE   = 2'd0,
        ACT_READ_BIN = 2'd1,
        ACT_READ_LOG = 2'd2,
        ACT_CLEAR    = 2'd3
    } t_action;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_BINNED  = 2'd0,
        OUT_LOGGED  = 2'd1,
        OUT_DROPPED = 2'd2,
        OUT_DONE    = 2'd3
    } t_outcome;

    typedef struct packed {
        t_action                action;
        logic [RAW_W-1:0]       raw_word;
        logic [STAMP_W-1:0]     timestamp;
        logic [INDEX_W-1:0]     index;
    } t_in_item;

    typedef struct packed {
        t_outcome               outcome;
        logic [COUNT_W-1:0]     data_word;
        logic [LEVEL_W-1:0]     event_level;
        logic [COUNT_W-1:0]     event_total;
    } t_out_item;

    typedef struct packed {
        logic                   en;
        logic [BIN_AW-1:0]      addr;
        logic [COUNT_W-1:0]     data;
    } t_bin_wr;

    typedef struct packed {
        logic [STAMP_W-1:0]     stamp;
        logic [LEVEL_W-1:0]     level;
    } t_log_entry;

    typedef struct packed {
        logic                   en;
        logic [LOG_AW-1:0]      addr;
        t_log_entry             entry;
    } t_log_wr;

endpackage

### rtl/core/phhel_in_if.sv
interface phhel_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [phhel_pkg::ACTION_W-1:0]         action;
    logic [phhel_pkg::RAW_W-1:0]            raw_word;
    logic [phhel_pkg::STAMP_W-1:0]          timestamp;
    logic [phhel_pkg::INDEX_W-1:0]          index;

    modport source (output valid, action, raw_word, timestamp, index, input ready);
    modport sink (input valid, action, raw_word, timestamp, index, output ready);
endinterface

### rtl/core/phhel_out_if.sv
interface phhel_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [phhel_pkg::OUTCOME_W-1:0]        outcome;
    logic [phhel_pkg::COUNT_W-1:0]          data_word;
    logic [phhel_pkg::LEVEL_W-1:0]          event_level;
    logic [phhel_pkg::COUNT_W-1:0]          event_total;

    modport source (output valid, outcome, data_word, event_level, event_total, input ready);
    modport sink (input valid, outcome, data_word, event_level, event_total, output ready);
endinterface

### rtl/core/pulse_height_histogram_event_log_unit.sv
// Pulse-height histogram with an event log.
// Items enter on i_in (valid/ready): a sample, a bin read, a log read or a clear.
// Each item gives exactly one result beat on o_out (valid/ready), in order.
// A sample takes level = raw_word >> 2. Levels below the threshold register
// (clamped to the bin count) count up their bin, saturating at 65535; other
// levels are events, logged with their timestamp while the log has room, and
// the event total counts them all, saturating at 65535.
// The user must write the threshold through i_cfg_we/i_cfg_data while the block is
// idle; the block does not enforce this. An accepted item first goes to a stage
// that reads the memories; the next stage holds the result and drives o_out.
// Throughput is one item per cycle while o_out does not stall; the bin update is a
// read-modify-write whose last write is bypassed into the following read.
// When o_out stalls, the result holds, one more item waits in the compute stage,
// and then i_in.ready drops until the result beat is taken.
// Reset clears the histogram and the event total and sets the threshold to 64;
// no sweep is needed. The log contents are undefined until written.
`include "assert_macros.svh"

module pulse_height_histogram_event_log_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [phhel_pkg::THRESH_W-1:0]      i_cfg_data,
    phhel_in_if.sink                            i_in,
    phhel_out_if.source                         o_out
);

    logic [phhel_pkg::THRESH_W-1:0]         r_threshold;
    logic                                   r_s1_vld;
    phhel_pkg::t_in_item                    r_s1;
    logic                                   r_out_vld;
    phhel_pkg::t_out_item                   r_out;
    logic [phhel_pkg::COUNT_W-1:0]          r_events;

    logic                                   w_in_acc;
    logic                                   w_s1_adv;
    logic [phhel_pkg::BIN_AW-1:0]           w_bin_rd_addr;
    logic [phhel_pkg::COUNT_W-1:0]          w_bin_val;
    phhel_pkg::t_log_entry                  w_log_val;
    logic [phhel_pkg::LEVEL_W-1:0]          w_level;
    logic                                   w_is_bin;
    logic                                   w_log_room;
    logic [phhel_pkg::COUNT_W-1:0]          w_events_inc;
    logic [phhel_pkg::COUNT_W-1:0]          n_events;
    phhel_pkg::t_out_item                   n_out;
    phhel_pkg::t_bin_wr                     w_bin_wr;
    phhel_pkg::t_log_wr                     w_log_wr;
    logic                                   w_clr;

    assign w_s1_adv = r_s1_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_s1_vld || w_s1_adv;
    assign w_in_acc = i_in.valid && i_in.ready;

    assign w_bin_rd_addr = (i_in.action == phhel_pkg::ACT_SAMPLE)
        ? phhel_pkg::BIN_AW'(i_in.raw_word[phhel_pkg::RAW_W-1:phhel_pkg::LEVEL_SHIFT])
        : phhel_pkg::BIN_AW'(i_in.index);

    phhel_bin_store u_bin_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (w_bin_rd_addr),
        .i_wr      (w_bin_wr),
        .i_clr     (w_clr),
        .o_rd_data (w_bin_val)
    );

    phhel_log_store u_log_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (phhel_pkg::LOG_AW'(i_in.index)),
        .i_wr      (w_log_wr),
        .o_rd_data (w_log_val)
    );

    assign w_level = r_s1.raw_word[phhel_pkg::RAW_W-1:phhel_pkg::LEVEL_SHIFT];
    assign w_is_bin = (int'(w_level) < int'(r_threshold)) && (int'(w_level) < phhel_pkg::BIN_COUNT);
    assign w_log_room = int'(r_events) < phhel_pkg::LOG_DEPTH;
    assign w_events_inc = (r_events == phhel_pkg::COUNT_SAT) ? r_events : r_events + 1'b1;

    always_comb begin
        n_out = '{outcome: phhel_pkg::OUT_DONE, data_word: '0, event_level: '0,
                  event_total: '0};
        n_events = r_events;
        w_bin_wr = '{en: 1'b0, addr: phhel_pkg::BIN_AW'(w_level), data: '0};
        w_log_wr = '{en: 1'b0, addr: phhel_pkg::LOG_AW'(r_events),
                     entry: '{stamp: r_s1.timestamp, level: w_level}};
        w_clr = 1'b0;
        unique case (r_s1.action)
            phhel_pkg::ACT_SAMPLE: begin
                n_out.event_level = w_level;
                if (w_is_bin) begin
                    n_out.outcome = phhel_pkg::OUT_BINNED;
                    w_bin_wr.en = w_s1_adv;
                    w_bin_wr.data = (w_bin_val == phhel_pkg::COUNT_SAT)
                        ? w_bin_val : w_bin_val + 1'b1;
                end else begin
                    n_events = w_events_inc;
                    if (w_log_room) begin
                        n_out.outcome = phhel_pkg::OUT_LOGGED;
                        w_log_wr.en = w_s1_adv;
                    end else begin
                        n_out.outcome = phhel_pkg::OUT_DROPPED;
                    end
                end
            end
            phhel_pkg::ACT_READ_BIN: begin
                if (int'(r_s1.index) < phhel_pkg::BIN_COUNT) begin
                    n_out.data_word = w_bin_val;
                end
            end
            phhel_pkg::ACT_READ_LOG: begin
                if (int'(r_s1.index) < phhel_pkg::LOG_DEPTH) begin
                    n_out.data_word = w_log_val.stamp;
                    n_out.event_level = w_log_val.level;
                end
            end
            phhel_pkg::ACT_CLEAR: begin
                n_events = '0;
                w_clr = w_s1_adv;
            end
            default: begin
            end
        endcase
        n_out.event_total = n_events;
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1 <= '{action: phhel_pkg::t_action'(i_in.action), raw_word: i_in.raw_word,
                      timestamp: i_in.timestamp, index: i_in.index};
        end
        if (w_s1_adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_events    <= '0;
            r_threshold <= phhel_pkg::THRESH_RESET;
        end else begin
            if (w_in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_vld <= 1'b1;
                r_events  <= n_events;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                r_threshold <= i_cfg_data;
            end
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.outcome     = r_out.outcome;
    assign o_out.data_word   = r_out.data_word;
    assign o_out.event_level = r_out.event_level;
    assign o_out.event_total = r_out.event_total;

    `ASSERT_IMPL(a_binned_level_in_range,
        o_out.valid && (o_out.outcome == phhel_pkg::OUT_BINNED),
        (int'(o_out.event_level) < phhel_pkg::BIN_COUNT) && (o_out.data_word == '0),
        "binned result carries a level outside the histogram")
    `ASSERT_IMPL(a_dropped_only_when_full,
        o_out.valid && (o_out.outcome == phhel_pkg::OUT_DROPPED),
        int'(o_out.event_total) > phhel_pkg::LOG_DEPTH,
        "event dropped while the log still had room")
    `ASSERT_NEXT(a_event_counted,
        w_s1_adv && (r_s1.action == phhel_pkg::ACT_SAMPLE) && !w_is_bin
            && (r_events != phhel_pkg::COUNT_SAT),
        r_events == phhel_pkg::COUNT_W'($past(r_events) + 1'b1),
        "event total did not advance on an event")
    `ASSERT_NEXT(a_clear_resets_total,
        w_s1_adv && (r_s1.action == phhel_pkg::ACT_CLEAR),
        r_events == '0,
        "event total not zero after a clear")

endmodule

### rtl/core/phhel_bin_store.sv
module phhel_bin_store (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_rd_en,
    input  logic [phhel_pkg::BIN_AW-1:0]        i_rd_addr,
    input  phhel_pkg::t_bin_wr                  i_wr,
    input  logic                                i_clr,
    output logic [phhel_pkg::COUNT_W-1:0]       o_rd_data
);

    logic [phhel_pkg::COUNT_W-1:0]  r_mem [phhel_pkg::BIN_COUNT];
    logic [phhel_pkg::COUNT_W-1:0]  r_q;
    logic [phhel_pkg::BIN_AW-1:0]   r_rd_addr;
    logic [phhel_pkg::BIN_COUNT-1:0] r_vld;
    logic                           r_fwd_vld;
    logic [phhel_pkg::BIN_AW-1:0]   r_fwd_addr;
    logic [phhel_pkg::COUNT_W-1:0]  r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_q       <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_fwd_addr <= i_wr.addr;
            r_fwd_data <= i_wr.data;
        end
    end

    // A cleared or never written bin reads as zero; the last write bypasses the array.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_fwd_vld <= 1'b0;
        end else if (i_clr) begin
            r_vld     <= '0;
            r_fwd_vld <= 1'b0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
            r_fwd_vld        <= 1'b1;
        end
    end

    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_rd_addr)) begin
            o_rd_data = r_fwd_data;
        end else if (r_vld[r_rd_addr]) begin
            o_rd_data = r_q;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

### rtl/core/phhel_log_store.sv
module phhel_log_store (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_rd_en,
    input  logic [phhel_pkg::LOG_AW-1:0]        i_rd_addr,
    input  phhel_pkg::t_log_wr                  i_wr,
    output phhel_pkg::t_log_entry               o_rd_data
);

    phhel_pkg::t_log_entry          r_mem [phhel_pkg::LOG_DEPTH];
    phhel_pkg::t_log_entry          r_q;
    logic [phhel_pkg::LOG_AW-1:0]   r_rd_addr;
    logic                           r_fwd_vld;
    logic [phhel_pkg::LOG_AW-1:0]   r_fwd_addr;
    phhel_pkg::t_log_entry          r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.entry;
            r_fwd_addr       <= i_wr.addr;
            r_fwd_data       <= i_wr.entry;
        end
        if (i_rd_en) begin
            r_q       <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else if (i_wr.en) begin
            r_fwd_vld <= 1'b1;
        end
    end

    assign o_rd_data = (r_fwd_vld && (r_fwd_addr == r_rd_addr)) ? r_fwd_data : r_q;

endmodule
